// ===== hw/rtl/tpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpsd_pkg
// Shared types and constants for the touch pad swipe detector.
// ----------------------------------------------------------------------------
package tpsd_pkg;

  localparam int unsigned LevelW = 22;
  localparam int unsigned XW     = 9;
  localparam int unsigned YW     = 24;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SpeedW = 34;

  // configuration register indexes
  localparam logic [2:0] REG_CHANNELS = 3'd0;
  localparam logic [2:0] REG_LEVEL0   = 3'd1;
  localparam logic [2:0] REG_LEVEL1   = 3'd2;
  localparam logic [2:0] REG_LEVEL2   = 3'd3;
  localparam logic [2:0] REG_LEVEL3   = 3'd4;
  localparam logic [2:0] REG_MIN_DIST = 3'd5;
  localparam logic [2:0] REG_TIMEOUT  = 3'd6;
  localparam logic [2:0] REG_MIN_PTS  = 3'd7;

  // direction codes
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,    // waiting for a tick
    ST_DIV_PT,  // averaging the touched positions
    ST_PUSH,    // write the averaged point
    ST_RD_A,    // read first trail point
    ST_RD_B,    // read last trail point
    ST_SQX,     // dx squared
    ST_SQY,     // dy squared, compare with limit
    ST_SQRT,    // square root of d2
    ST_MUL,     // root times 1000
    ST_DIV_SP,  // speed division
    ST_OUT      // result waiting
  } state_t;

endpackage

// ===== hw/rtl/touch_pad_swipe_detector.sv =====
// ----------------------------------------------------------------------------
// touch_pad_swipe_detector
// Scans touch channels per tick, keeps a trail of touch points and reports
// a swipe with direction, speed and duration on release.
// ----------------------------------------------------------------------------
// A touched tick is taken, then in_tready returns after the 25-step averaging
// divider and one trail write. A release that gives a swipe raises out_tvalid
// after two trail reads, squares, a 32-step root, the multiply and a 64-step
// speed divider (both skipped when the duration is zero); a release with no
// swipe frees the input at once or after the reads and squares. One request
// at a time. Sync reset clears touch state, pointers, registers; not the trail.
module touch_pad_swipe_detector #(
  parameter int unsigned TRAIL_DEPTH = 32,
  parameter int unsigned CHANNELS    = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  // config port
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_wdata,
  // input: now_ms[31:0], read_ok[35:32], reading_0..3 [57:36]..[123:102]
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,
  // output: swipe_direction[1:0], swipe_speed[35:2], swipe_duration_ms[67:36],
  //         event_time_ms[99:68]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [103:0]  out_tdata
);

  localparam int unsigned AW = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TRAIL_DEPTH + 1);
  localparam int unsigned PW = tpsd_pkg::XW + tpsd_pkg::YW + tpsd_pkg::TimeW;

  // configuration
  logic [2:0]  chan_r;
  logic [21:0] level_r [4];
  logic [23:0] min_dist_r;
  logic [31:0] timeout_r;
  logic [7:0]  min_pts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r     <= '0;
      level_r[0] <= '0;
      level_r[1] <= '0;
      level_r[2] <= '0;
      level_r[3] <= '0;
      min_dist_r <= 24'd50;
      timeout_r  <= 32'd1000;
      min_pts_r  <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        tpsd_pkg::REG_CHANNELS: chan_r     <= cfg_wdata[2:0];
        tpsd_pkg::REG_LEVEL0:   level_r[0] <= cfg_wdata[21:0];
        tpsd_pkg::REG_LEVEL1:   level_r[1] <= cfg_wdata[21:0];
        tpsd_pkg::REG_LEVEL2:   level_r[2] <= cfg_wdata[21:0];
        tpsd_pkg::REG_LEVEL3:   level_r[3] <= cfg_wdata[21:0];
        tpsd_pkg::REG_MIN_DIST: min_dist_r <= cfg_wdata[23:0];
        tpsd_pkg::REG_TIMEOUT:  timeout_r  <= cfg_wdata;
        tpsd_pkg::REG_MIN_PTS:  min_pts_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // input scan: sums of touched channels (narrow, parallel over channels)
  logic [31:0] now_in;
  logic [3:0]  ok_in;
  logic [21:0] rd_in [4];
  logic [2:0]  hits_c;
  logic [9:0]  sx_c;
  logic [24:0] sy_c;
  logic [2:0]  nch;

  assign now_in   = in_tdata[31:0];
  assign ok_in    = in_tdata[35:32];
  assign rd_in[0] = in_tdata[57:36];
  assign rd_in[1] = in_tdata[79:58];
  assign rd_in[2] = in_tdata[101:80];
  assign rd_in[3] = in_tdata[123:102];
  assign nch = (chan_r > 3'(CHANNELS)) ? 3'(CHANNELS) : chan_r;

  always_comb begin
    hits_c = '0;
    sx_c   = '0;
    sy_c   = '0;
    for (int i = 0; i < 4; i++) begin
      if ((3'(i) < nch) && ok_in[i] && (rd_in[i] < level_r[i])) begin
        hits_c = hits_c + 3'd1;
        sx_c   = sx_c + 10'(100 * i);
        sy_c   = sy_c + {2'b0, level_r[i] - rd_in[i], 1'b0};
      end
    end
  end

  // state
  tpsd_pkg::state_t st_r, st_nxt;
  logic          touching_r;
  logic [31:0]   start_r;
  logic [AW-1:0] oldest_r;
  logic [CW-1:0] count_r;
  logic [31:0]   now_r;

  // shared restoring divider/sqrt unit registers
  logic [63:0]  num_r;    // dividend / radicand shift
  logic [63:0]  rem_r;    // partial remainder
  logic [63:0]  quo_r;    // quotient / root
  logic [31:0]  den_r;
  logic [6:0]   cnt_r;
  logic [9:0]   sx_r;
  logic [2:0]   hits_r;

  // trail data
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en;
  logic [PW-1:0] wr_data, rd_data;
  logic [PW-1:0] pa_r;
  logic [8:0]    px_r;

  tpsd_ram #(.WIDTH(PW), .DEPTH(TRAIL_DEPTH)) u_trail (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // result
  logic [1:0]  dir_r;
  logic [31:0] dur_r;
  logic [33:0] speed_r;
  logic [47:0] d2_r;
  logic [23:0] ady_r;

  // ring addressing
  logic [CW:0] wsum, lsum;
  logic [AW-1:0] wslot, lslot;
  assign wsum  = {1'b0, CW'(oldest_r)} + {1'b0, count_r};
  assign wslot = (wsum >= (CW+1)'(TRAIL_DEPTH)) ? AW'(wsum - (CW+1)'(TRAIL_DEPTH))
                                                : AW'(wsum);
  assign lsum  = wsum - (CW+1)'(1);
  assign lslot = (lsum >= (CW+1)'(TRAIL_DEPTH)) ? AW'(lsum - (CW+1)'(TRAIL_DEPTH))
                                                : AW'(lsum);
  logic full;
  assign full = (count_r == CW'(TRAIL_DEPTH));

  // divider step
  logic [64:0] dtrial;
  logic [63:0] drem;
  assign drem   = {rem_r[62:0], num_r[63]};
  assign dtrial = {1'b0, drem} - {33'b0, den_r};

  // sqrt step: two radicand bits per cycle
  logic [65:0] srem;
  logic [65:0] strial;
  assign srem   = {rem_r, num_r[63:62]};
  assign strial = srem - {quo_r, 2'b01};

  // displacement
  logic [9:0]  dx_s;
  logic [24:0] dy_s;
  logic [8:0]  adx;
  logic [23:0] ady;
  assign dx_s = {1'b0, rd_data[PW-1 -: 9]} - {1'b0, pa_r[PW-1 -: 9]};
  assign dy_s = {1'b0, rd_data[55:32]} - {1'b0, pa_r[55:32]};
  assign adx  = dx_s[9]  ? 9'(-dx_s)  : dx_s[8:0];
  assign ady  = dy_s[24] ? 24'(-dy_s) : dy_s[23:0];

  logic release_ok;
  assign release_ok = (count_r >= CW'(2)) && (32'(min_pts_r) <= 32'(count_r));

  logic timed_out;
  assign timed_out = (now_r - start_r) > timeout_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tpsd_pkg::ST_IDLE:
        if (in_tvalid) begin
          if (hits_c != 0) st_nxt = tpsd_pkg::ST_DIV_PT;
          else if (touching_r && release_ok) st_nxt = tpsd_pkg::ST_RD_A;
        end
      tpsd_pkg::ST_DIV_PT: if (cnt_r == 7'd0) st_nxt = tpsd_pkg::ST_PUSH;
      tpsd_pkg::ST_PUSH:   st_nxt = tpsd_pkg::ST_IDLE;
      tpsd_pkg::ST_RD_A:   st_nxt = tpsd_pkg::ST_RD_B;
      tpsd_pkg::ST_RD_B:   st_nxt = tpsd_pkg::ST_SQX;
      tpsd_pkg::ST_SQX:    st_nxt = tpsd_pkg::ST_SQY;
      tpsd_pkg::ST_SQY:
        if ((d2_r + 48'(ady_r) * 48'(ady_r)) < 48'(min_dist_r) * 48'(min_dist_r))
          st_nxt = tpsd_pkg::ST_IDLE;
        else st_nxt = tpsd_pkg::ST_SQRT;
      tpsd_pkg::ST_SQRT:
        if (cnt_r == 7'd0) st_nxt = (dur_r == 0) ? tpsd_pkg::ST_OUT : tpsd_pkg::ST_MUL;
      tpsd_pkg::ST_MUL:    st_nxt = tpsd_pkg::ST_DIV_SP;
      tpsd_pkg::ST_DIV_SP: if (cnt_r == 7'd0) st_nxt = tpsd_pkg::ST_OUT;
      tpsd_pkg::ST_OUT:    if (out_tready) st_nxt = tpsd_pkg::ST_IDLE;
      default:             st_nxt = tpsd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = (st_r == tpsd_pkg::ST_IDLE);
    out_tvalid = (st_r == tpsd_pkg::ST_OUT);
    wr_en      = (st_r == tpsd_pkg::ST_PUSH);
    wr_addr    = full ? oldest_r : wslot;
    wr_data    = {px_r, quo_r[23:0], now_r};
    rd_addr    = (st_r == tpsd_pkg::ST_IDLE) ? oldest_r : lslot;
    out_tdata  = {4'b0, now_r, dur_r, speed_r, dir_r};
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= tpsd_pkg::ST_IDLE;
      touching_r <= 1'b0;
      start_r    <= '0;
      oldest_r   <= '0;
      count_r    <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        tpsd_pkg::ST_IDLE:
          if (in_tvalid) begin
            now_r  <= now_in;
            hits_r <= hits_c;
            sx_r   <= sx_c;
            if (hits_c != 0) begin
              if (!touching_r) begin
                touching_r <= 1'b1;
                start_r    <= now_in;
                oldest_r   <= '0;
                count_r    <= '0;
              end
              // y division first, x average from a case on the hit count later
              num_r <= {sy_c, 39'b0};
              rem_r <= '0;
              quo_r <= '0;
              den_r <= {29'b0, hits_c};
              cnt_r <= 7'd25;
            end else if (touching_r) begin
              touching_r <= 1'b0;
              if (!release_ok) begin
                oldest_r <= '0;
                count_r  <= '0;
              end
            end
          end
        tpsd_pkg::ST_DIV_PT: begin
          if (cnt_r == 7'd0) begin
            // x average: hits at most 4, values 0..600
            case (hits_r)
              3'd1: px_r <= 9'(sx_r);
              3'd2: px_r <= 9'(sx_r >> 1);
              3'd3: px_r <= 9'((20'(sx_r) * 20'd683) >> 11);
              3'd4: px_r <= 9'(sx_r >> 2);
              default: px_r <= '0;
            endcase
          end else begin
            num_r <= {num_r[62:0], 1'b0};
            cnt_r <= cnt_r - 7'd1;
            if (!dtrial[64]) begin
              rem_r <= dtrial[63:0];
              quo_r <= {quo_r[62:0], 1'b1};
            end else begin
              rem_r <= drem;
              quo_r <= {quo_r[62:0], 1'b0};
            end
          end
        end
        tpsd_pkg::ST_PUSH: begin
          if (timed_out) begin
            touching_r <= 1'b0;
            oldest_r   <= '0;
            count_r    <= '0;
          end else if (full) begin
            oldest_r <= (oldest_r == AW'(TRAIL_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
          end else begin
            count_r <= count_r + 1'b1;
          end
        end
        // first point was read at acceptance, last point read now
        tpsd_pkg::ST_RD_A: pa_r <= rd_data;
        tpsd_pkg::ST_RD_B: ;
        tpsd_pkg::ST_SQX: begin
          dur_r  <= rd_data[31:0] - pa_r[31:0];
          d2_r   <= 48'(adx) * 48'(adx);
          ady_r  <= ady;
          if ({15'b0, adx} > ady) dir_r <= dx_s[9] ? tpsd_pkg::DIR_LEFT : tpsd_pkg::DIR_RIGHT;
          else
            dir_r <= (!dy_s[24] && dy_s != 0) ? tpsd_pkg::DIR_DOWN : tpsd_pkg::DIR_UP;
          oldest_r <= '0;
          count_r  <= '0;
        end
        tpsd_pkg::ST_SQY: begin
          num_r <= {16'b0, d2_r + 48'(ady_r) * 48'(ady_r)};
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= 7'd32;
          speed_r <= '0;
        end
        tpsd_pkg::ST_SQRT: begin
          if (cnt_r != 7'd0) begin
            num_r <= {num_r[61:0], 2'b0};
            cnt_r <= cnt_r - 7'd1;
            if (!strial[65]) begin
              rem_r <= strial[63:0];
              quo_r <= {quo_r[62:0], 1'b1};
            end else begin
              rem_r <= srem[63:0];
              quo_r <= {quo_r[62:0], 1'b0};
            end
          end
        end
        tpsd_pkg::ST_MUL: begin
          num_r <= 64'(quo_r[24:0]) * 64'd1000;
          rem_r <= '0;
          quo_r <= '0;
          den_r <= dur_r;
          cnt_r <= 7'd64;
        end
        tpsd_pkg::ST_DIV_SP: begin
          if (cnt_r == 7'd0) speed_r <= quo_r[33:0];
          else begin
            num_r <= {num_r[62:0], 1'b0};
            cnt_r <= cnt_r - 7'd1;
            if (!dtrial[64]) begin
              rem_r <= dtrial[63:0];
              quo_r <= {quo_r[62:0], 1'b1};
            end else begin
              rem_r <= drem;
              quo_r <= {quo_r[62:0], 1'b0};
            end
          end
        end
        tpsd_pkg::ST_OUT: ;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tpsd_ram.sv =====
// ----------------------------------------------------------------------------
// tpsd_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module tpsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the touch pad swipe detector: ticks of readings go in,
// a built-in predictor works out each swipe and every result is compared.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DEPTH    = 32;
  localparam int unsigned SETTLE   = 400;
  localparam longint      MAX_CYC  = 2000000;

  // fields from the lowest bit up: dir, speed, dur, evt
  typedef struct packed {
    logic [31:0] evt;
    logic [31:0] dur;
    logic [33:0] speed;
    logic [1:0]  dir;
  } swipe_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [2:0]    cfg_index;
  logic [31:0]   cfg_wdata;
  logic          in_tvalid;
  logic          in_tready;
  logic [127:0]  in_tdata;
  logic          out_tvalid;
  logic          out_tready;
  logic [103:0]  out_tdata;

  touch_pad_swipe_detector dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  // predictor copy of registers and touch state
  logic [2:0]  p_chans;
  logic [21:0] p_level [4];
  logic [23:0] p_min_dist;
  logic [31:0] p_timeout;
  logic [7:0]  p_min_pts;
  bit          p_touching;
  logic [31:0] p_start;
  logic [8:0]  p_tx [DEPTH];
  logic [23:0] p_ty [DEPTH];
  logic [31:0] p_tt [DEPTH];
  int unsigned p_oldest, p_count;

  swipe_t      expected_swipes [$];
  bit          failed;
  longint      cycles;
  int unsigned burst_left;
  logic [31:0] now_ms;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stall pattern: phases of free flow and random stalls
  int unsigned stall_phase;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[8])
      out_tready <= 1'b1;
    else
      out_tready <= ($urandom_range(0, 3) != 0);
  end

  // result check
  always @(posedge clk) begin
    swipe_t got, exp_s;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[99:0];
      if (expected_swipes.size() == 0) begin
        $error("unexpected swipe %h", got);
        failed = 1;
      end else begin
        exp_s = expected_swipes.pop_front();
        if (got.dir !== exp_s.dir) begin
          $error("swipe_direction exp %0d got %0d", exp_s.dir, got.dir); failed = 1;
        end
        if (got.speed !== exp_s.speed) begin
          $error("swipe_speed exp %0d got %0d", exp_s.speed, got.speed); failed = 1;
        end
        if (got.dur !== exp_s.dur) begin
          $error("swipe_duration_ms exp %0d got %0d", exp_s.dur, got.dur); failed = 1;
        end
        if (got.evt !== exp_s.evt) begin
          $error("event_time_ms exp %0d got %0d", exp_s.evt, got.evt); failed = 1;
        end
      end
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void trail_reset();
    p_oldest = 0;
    p_count  = 0;
  endfunction

  // gesture on release
  function automatic void judge_release(logic [31:0] now);
    int unsigned f, l;
    longint sdx, sdy, ax, ay;
    longint unsigned d2, lim;
    logic [31:0] dur;
    swipe_t s;
    if (p_count < 2 || p_count < p_min_pts) return;
    f = p_oldest % DEPTH;
    l = (p_oldest + p_count - 1) % DEPTH;
    sdx = longint'(p_tx[l]) - longint'(p_tx[f]);
    sdy = longint'(p_ty[l]) - longint'(p_ty[f]);
    ax = sdx < 0 ? -sdx : sdx;
    ay = sdy < 0 ? -sdy : sdy;
    d2 = ax * ax + ay * ay;
    lim = longint'(p_min_dist) * longint'(p_min_dist);
    if (d2 < lim) return;
    if (ax > ay) s.dir = sdx > 0 ? tpsd_pkg::DIR_RIGHT : tpsd_pkg::DIR_LEFT;
    else s.dir = sdy > 0 ? tpsd_pkg::DIR_DOWN : tpsd_pkg::DIR_UP;
    dur = p_tt[l] - p_tt[f];
    s.speed = (dur == 0) ? 34'd0 : 34'((int_sqrt(d2) * 1000) / dur);
    s.dur = dur;
    s.evt = now;
    expected_swipes = {expected_swipes, s};
  endfunction

  // predictor for one tick
  function automatic void predict_tick(logic [127:0] d);
    logic [31:0] now;
    logic [3:0]  ok;
    logic [21:0] rd;
    int unsigned n, hits, sx, sy, slot;
    now = d[31:0];
    ok  = d[35:32];
    n = p_chans > 4 ? 4 : p_chans;
    hits = 0; sx = 0; sy = 0;
    for (int i = 0; i < n; i++) begin
      rd = d[36 + 22*i +: 22];
      if (ok[i] && rd < p_level[i]) begin
        hits++;
        sx += 100 * i;
        sy += 2 * (p_level[i] - rd);
      end
    end
    if (hits > 0) begin
      if (!p_touching) begin
        p_touching = 1;
        p_start = now;
        trail_reset();
      end
      if (p_count < DEPTH) begin
        slot = (p_oldest + p_count) % DEPTH;
        p_count++;
      end else begin
        slot = p_oldest;
        p_oldest = (slot + 1) % DEPTH;
      end
      p_tx[slot] = 9'(sx / hits);
      p_ty[slot] = 24'(sy / hits);
      p_tt[slot] = now;
    end else if (p_touching) begin
      p_touching = 0;
      judge_release(now);
      trail_reset();
    end
    if (p_touching && (now - p_start) > p_timeout) begin
      p_touching = 0;
      trail_reset();
    end
  endfunction

  task automatic wait_idle();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (expected_swipes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      tpsd_pkg::REG_CHANNELS: p_chans    = val[2:0];
      tpsd_pkg::REG_LEVEL0:   p_level[0] = val[21:0];
      tpsd_pkg::REG_LEVEL1:   p_level[1] = val[21:0];
      tpsd_pkg::REG_LEVEL2:   p_level[2] = val[21:0];
      tpsd_pkg::REG_LEVEL3:   p_level[3] = val[21:0];
      tpsd_pkg::REG_MIN_DIST: p_min_dist = val[23:0];
      tpsd_pkg::REG_TIMEOUT:  p_timeout  = val;
      tpsd_pkg::REG_MIN_PTS:  p_min_pts  = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_levels(logic [21:0] l0, l1, l2, l3);
    write_reg(tpsd_pkg::REG_LEVEL0, 32'(l0));
    write_reg(tpsd_pkg::REG_LEVEL1, 32'(l1));
    write_reg(tpsd_pkg::REG_LEVEL2, 32'(l2));
    write_reg(tpsd_pkg::REG_LEVEL3, 32'(l3));
  endtask

  // send one request; bursts with random gaps between them
  task automatic send_tick(logic [31:0] t, logic [3:0] ok,
                           logic [21:0] r0, r1, r2, r3);
    logic [127:0] d;
    int unsigned gap;
    d = {4'b0, r3, r2, r1, r0, ok, t};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    predict_tick(d);
  endtask

  function automatic logic [21:0] rnd22();
    return 22'($urandom());
  endfunction

  // reading for channel i that lands at an offset under its level
  function automatic logic [21:0] under(int i, int unsigned off);
    return (p_level[i] > off) ? 22'(p_level[i] - off) : 22'd0;
  endfunction

  task automatic test_directed();
    write_reg(tpsd_pkg::REG_CHANNELS, 32'd4);
    set_levels(22'd1000, 22'd1000, 22'd1000, 22'd1000);
    write_reg(tpsd_pkg::REG_MIN_DIST, 32'd10);
    write_reg(tpsd_pkg::REG_MIN_PTS, 32'd3);
    write_reg(tpsd_pkg::REG_TIMEOUT, 32'd1000);
    now_ms = 32'd100;
    // rightward swipe: channel 0 then channel 3
    send_tick(now_ms, 4'h1, 22'd900, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF);
    send_tick(now_ms + 32'd10, 4'h3, 22'd900, 22'd900, 22'h3FFFFF, 22'h3FFFFF);
    send_tick(now_ms + 32'd20, 4'h8, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'd900);
    send_tick(now_ms + 32'd30, 4'hF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF);
    // leftward
    send_tick(32'd200, 4'h8, 22'd0, 22'd0, 22'd0, 22'd999);
    send_tick(32'd210, 4'hF, 22'd0, 22'd0, 22'd0, 22'd999);
    send_tick(32'd220, 4'h1, 22'd999, 22'd0, 22'd0, 22'd0);
    send_tick(32'd230, 4'h0, 22'd0, 22'd0, 22'd0, 22'd0);
    // downward and axis tie going up, zero duration
    send_tick(32'd300, 4'h1, 22'd990, 22'd0, 22'd0, 22'd0);
    send_tick(32'd300, 4'h1, 22'd900, 22'd0, 22'd0, 22'd0);
    send_tick(32'd300, 4'h1, 22'd100, 22'd0, 22'd0, 22'd0);
    send_tick(32'd300, 4'h0, 22'd0, 22'd0, 22'd0, 22'd0);
    send_tick(32'd400, 4'h1, 22'd500, 22'd0, 22'd0, 22'd0);
    send_tick(32'd401, 4'h3, 22'd500, 22'd550, 22'd0, 22'd0);
    send_tick(32'd402, 4'h2, 22'd0, 22'd550, 22'd0, 22'd0);
    send_tick(32'd403, 4'h0, 22'd0, 22'd0, 22'd0, 22'd0);
    // too few points, then a touch across the time wrap within the timeout
    send_tick(32'd500, 4'h1, 22'd0, 22'd0, 22'd0, 22'd0);
    send_tick(32'd501, 4'h0, 22'd0, 22'd0, 22'd0, 22'd0);
    send_tick(32'hFFFF_FF00, 4'h1, 22'd0, 22'd0, 22'd0, 22'd0);
    send_tick(32'h0000_0100, 4'h1, 22'd10, 22'd0, 22'd0, 22'd0);
    send_tick(32'h0000_0110, 4'h0, 22'd0, 22'd0, 22'd0, 22'd0);
    wait_idle();
  endtask

  // well-formed swipes with random content, some noise between them
  task automatic run_swipes(int unsigned count, int unsigned max_len,
                            logic [31:0] max_step);
    int unsigned len;
    logic [3:0] ok;
    logic [21:0] r [4];
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_tick($urandom(), 4'($urandom()), rnd22(), rnd22(), rnd22(), rnd22());
        k++;
        continue;
      end
      len = $urandom_range(1, max_len);
      for (int j = 0; j < len && k < count; j++, k++) begin
        now_ms += $urandom_range(0, max_step);
        ok = 4'($urandom_range(1, 15));
        for (int i = 0; i < 4; i++)
          r[i] = ($urandom_range(0, 2) != 0) ? under(i, $urandom_range(1, 4000))
                                               : rnd22();
        send_tick(now_ms, ok, r[0], r[1], r[2], r[3]);
      end
      now_ms += $urandom_range(0, max_step);
      send_tick(now_ms, 4'($urandom()), 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF);
    end
  endtask

  task automatic test_random_mid();
    write_reg(tpsd_pkg::REG_CHANNELS, 32'd4);
    set_levels(22'd3000, 22'd2000, 22'd4000, 22'd1500);
    write_reg(tpsd_pkg::REG_MIN_DIST, 32'd50);
    write_reg(tpsd_pkg::REG_TIMEOUT, 32'd1000);
    write_reg(tpsd_pkg::REG_MIN_PTS, 32'd3);
    run_swipes(350, 12, 32'd40);
    wait_idle();
  endtask

  task automatic test_random_extremes();
    // full levels, long trails that wrap, zero thresholds
    write_reg(tpsd_pkg::REG_CHANNELS, 32'd7);
    set_levels(22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF);
    write_reg(tpsd_pkg::REG_MIN_DIST, 32'd0);
    write_reg(tpsd_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(tpsd_pkg::REG_MIN_PTS, 32'd0);
    run_swipes(300, 45, 32'hFFFF);
    wait_idle();
    write_reg(tpsd_pkg::REG_CHANNELS, 32'd2);
    set_levels(22'd600, 22'd5000, 22'd0, 22'd0);
    write_reg(tpsd_pkg::REG_MIN_DIST, 32'hFF_FFFF);
    write_reg(tpsd_pkg::REG_TIMEOUT, 32'd0);
    write_reg(tpsd_pkg::REG_MIN_PTS, 32'd255);
    run_swipes(60, 8, 32'd3);
    wait_idle();
    write_reg(tpsd_pkg::REG_CHANNELS, 32'd1);
    set_levels(22'd4000, 22'd100, 22'd100, 22'd100);
    write_reg(tpsd_pkg::REG_MIN_DIST, 32'd5);
    write_reg(tpsd_pkg::REG_TIMEOUT, 32'd200);
    write_reg(tpsd_pkg::REG_MIN_PTS, 32'd2);
    run_swipes(240, 10, 32'd30);
    wait_idle();
  endtask

  initial begin
    rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_tvalid = 0; in_tdata = '0; out_tready = 0;
    cycles = 0; stall_phase = 0; failed = 0; burst_left = 0;
    p_chans = 0; p_level = '{default: '0}; p_min_dist = 24'd50;
    p_timeout = 32'd1000; p_min_pts = 8'd3; p_touching = 0; p_start = 0;
    trail_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mid();
    test_random_extremes();
    if (!failed)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== touch_pad_swipe_detector.f =====
hw/rtl/tpsd_pkg.sv
hw/rtl/tpsd_ram.sv
hw/rtl/touch_pad_swipe_detector.sv
tb/tb.sv
